### hdl/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Field widths, command and character codes, register indexes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // field widths
   localparam int CMD_W      = 2;
   localparam int CHAR_W     = 8;
   localparam int CUR_W      = 12;
   localparam int CELL_W     = 16;
   localparam int ATTR_W     = 8;
   localparam int COLS_W     = 8;
   localparam int ROWS_W     = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // remainder unit: one bit of the cursor per step
   localparam int DIV_STEPS  = CUR_W;
   localparam int DIV_CNT_W  = 4;

   // commands
   localparam logic [CMD_W-1:0] CMD_OUTPUT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ECHO   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

   // character codes
   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ATTRIBUTE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS      = 2'd2;

   // register reset values
   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
   localparam logic [COLS_W-1:0] COLS_RESET = 8'd80;
   localparam logic [ROWS_W-1:0] ROWS_RESET = 6'd25;

   localparam logic [CUR_W-1:0] LINE_MAX = 12'hFFF;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_DIV_WAIT,
      ST_READ_DATA,
      ST_SCROLL_CHECK,
      ST_SCROLL_RD,
      ST_SCROLL_WR,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_READ,
      OP_NEWLINE,
      OP_RETURN,
      OP_TAB,
      OP_WRITE
   } op_type;

endpackage

### hdl/tcw_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_channels: request and response channels of the text console writer
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface tcw_req_if;
   logic                        valid;
   logic                        ready;
   logic [tcw_pkg::CMD_W-1:0]   cmd;
   logic [tcw_pkg::CHAR_W-1:0]  char_code;
   logic [tcw_pkg::CUR_W-1:0]   cell_index;

   modport source (output valid, output cmd, output char_code, output cell_index,
                   input ready);
   modport sink   (input valid, input cmd, input char_code, input cell_index,
                   output ready);
endinterface

interface tcw_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tcw_pkg::CUR_W-1:0]   cursor;
   logic [tcw_pkg::CELL_W-1:0]  read_data;
   logic                        line_done;
   logic                        scrolled;

   modport source (output valid, output cursor, output read_data, output line_done,
                   output scrolled, input ready);
   modport sink   (input valid, input cursor, input read_data, input line_done,
                   input scrolled, output ready);
endinterface

### hdl/tcw_rem_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_rem_unit: iterative remainder unit
// Restoring division of a 12-bit value, one bit per cycle; a value already
// below the divisor is taken as the remainder without iterating.
// ----------------------------------------------------------------------------
module tcw_rem_unit #(
   parameter int DV_W = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [tcw_pkg::CUR_W-1:0] dividend,
   input  logic [DV_W-1:0]           divisor,
   output logic                      done,
   output logic [DV_W-1:0]           rem
);

   localparam int CW = (DV_W > tcw_pkg::CUR_W) ? DV_W : tcw_pkg::CUR_W;

   logic                          busy_ff;
   logic                          done_ff;
   logic [tcw_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic [tcw_pkg::CUR_W-1:0]     dvd_ff;
   logic [DV_W-1:0]               dvs_ff;
   logic [DV_W-1:0]               rem_ff;

   logic [DV_W:0] trial;
   logic [DV_W:0] diff;
   logic          fits;
   logic [CW-1:0] dvd_ext;
   logic          below;

   assign dvd_ext = CW'(dividend);
   assign below   = dvd_ext < CW'(divisor);
   assign trial   = {rem_ff, dvd_ff[tcw_pkg::CUR_W-1]};
   assign diff    = trial - {1'b0, dvs_ff};
   assign fits    = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            if (below) begin
               rem_ff  <= dvd_ext[DV_W-1:0];
               done_ff <= 1'b1;
               busy_ff <= 1'b0;
            end else begin
               rem_ff  <= '0;
               dvd_ff  <= dividend;
               dvs_ff  <= divisor;
               cnt_ff  <= tcw_pkg::DIV_CNT_W'(tcw_pkg::DIV_STEPS);
               busy_ff <= 1'b1;
            end
         end else if (busy_ff) begin
            rem_ff <= fits ? diff[DV_W-1:0] : trial[DV_W-1:0];
            dvd_ff <= {dvd_ff[tcw_pkg::CUR_W-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == tcw_pkg::DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

### hdl/tcw_cell_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_cell_ram: screen cell store
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [AW-1:0]              waddr,
   input  logic [tcw_pkg::CELL_W-1:0] wdata,
   input  logic                       re,
   input  logic [AW-1:0]              raddr,
   output logic [tcw_pkg::CELL_W-1:0] rdata
);

   logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];
   logic [tcw_pkg::CELL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hdl/text_console_char_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer: text-mode console character engine
// Keeps the screen cells, the cursor and the echo line length, and handles
// output, echo and cell-read transactions one at a time.
// ----------------------------------------------------------------------------
// After reset the block sweeps the cell store to zero, one cell a cycle;
// requests are held off meanwhile, register writes are taken. A transaction is
// then worked on alone by a small sequencer around one shared remainder unit.
// A printable character, a backspace or a read passes through the remainder
// unit; an ignored character or the unused command skips it. Newline, return
// and tab divide the cursor one bit per cycle (a cursor already below the
// divisor skips the division). A scroll copies the screen through the cell
// store, which has one read and one write port: each moved cell is read and
// then written, each blanked cell is only written. A finished response sits
// in an output register, so the next request is taken while it waits; the one
// after that stalls until the register is free.
// ----------------------------------------------------------------------------
module text_console_char_writer #(
   parameter int MAX_CELLS = 4096,
   parameter int TAB_WIDTH = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   tcw_req_if.sink                        req_chan,
   tcw_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // address, screen-size and divisor widths
   localparam int AW   = $clog2(MAX_CELLS);
   localparam int SZ_W = $clog2(MAX_CELLS + 1);
   localparam int DV_W = (SZ_W > tcw_pkg::COLS_W) ? SZ_W : tcw_pkg::COLS_W;
   localparam int WC_W = tcw_pkg::CUR_W + 1;   // working cursor, may pass the screen

   localparam logic [DV_W-1:0] DIV_CELLS = DV_W'(MAX_CELLS);
   localparam logic [DV_W-1:0] DIV_TAB   = DV_W'(TAB_WIDTH);
   localparam logic [AW-1:0]   LAST_CELL = AW'(MAX_CELLS - 1);

   // configuration
   logic [tcw_pkg::ATTR_W-1:0] attr_ff;
   logic [tcw_pkg::COLS_W-1:0] cols_ff;
   logic [tcw_pkg::ROWS_W-1:0] rows_ff;

   // sequencer and working state
   tcw_pkg::state_type         state_ff, state_in;
   tcw_pkg::op_type            op_ff, op_in;
   logic [AW-1:0]              clr_ff;
   logic [tcw_pkg::CMD_W-1:0]  cmd_ff;
   logic [tcw_pkg::CHAR_W-1:0] ch_ff;
   logic [tcw_pkg::CUR_W-1:0]  idx_ff;
   logic [tcw_pkg::CHAR_W-1:0] wch_ff;
   logic [WC_W-1:0]            cur_ff;
   logic [tcw_pkg::CUR_W-1:0]  pos_ff;
   logic [tcw_pkg::CUR_W-1:0]  line_len_ff;
   logic [SZ_W-1:0]            size_ff;
   logic [AW-1:0]              scan_ff;
   logic [tcw_pkg::CELL_W-1:0] rd_ff;
   logic                       done_ff;
   logic                       scr_ff;

   // response register
   logic                       rsp_valid_ff;
   logic [tcw_pkg::CUR_W-1:0]  rsp_cursor_ff;
   logic [tcw_pkg::CELL_W-1:0] rsp_data_ff;
   logic                       rsp_done_ff;
   logic                       rsp_scr_ff;

   // shared remainder unit and cell store ports
   logic                       div_start;
   logic [tcw_pkg::CUR_W-1:0]  div_dividend;
   logic [DV_W-1:0]            div_divisor;
   logic                       div_done;
   logic [DV_W-1:0]            div_rem;

   logic                       ram_we;
   logic [AW-1:0]              ram_waddr;
   logic [tcw_pkg::CELL_W-1:0] ram_wdata;
   logic                       ram_re;
   logic [AW-1:0]              ram_raddr;
   logic [tcw_pkg::CELL_W-1:0] ram_rdata;

   // derived values
   logic [tcw_pkg::COLS_W-1:0] cols_eff;
   logic [tcw_pkg::ROWS_W-1:0] rows_eff;
   logic [15:0]                prod;
   logic [SZ_W-1:0]            size_in;
   logic                       is_echo;
   logic                       is_bs;
   logic [tcw_pkg::CUR_W-1:0]  bs_cur;
   logic [15:0]                size16;
   logic [15:0]                src16;
   logic                       scan_last;
   logic [WC_W-1:0]            cur_base;
   logic [WC_W-1:0]            cur_post;
   logic                       rsp_load;

   // a geometry of zero counts as one; the screen never exceeds the store
   assign cols_eff = (cols_ff == '0) ? tcw_pkg::COLS_W'(1) : cols_ff;
   assign rows_eff = (rows_ff == '0) ? tcw_pkg::ROWS_W'(1) : rows_ff;
   assign prod     = 16'(cols_eff) * 16'(rows_eff);
   assign size_in  = (prod > 16'(MAX_CELLS)) ? SZ_W'(MAX_CELLS) : prod[SZ_W-1:0];

   assign is_echo = (cmd_ff == tcw_pkg::CMD_ECHO);
   assign is_bs   = is_echo && (ch_ff == tcw_pkg::CH_BS);
   // backspace steps back only while the input line has characters
   assign bs_cur  = ((line_len_ff != '0) && (pos_ff != '0)) ? pos_ff - 1'b1 : pos_ff;

   assign size16    = 16'(size_ff);
   assign src16     = 16'(scan_ff) + 16'(cols_eff);
   assign scan_last = (16'(scan_ff) + 16'd1) == size16;

   // row or tab-stop start of the cursor, from the remainder
   assign cur_base = WC_W'(pos_ff) - WC_W'(div_rem[tcw_pkg::COLS_W-1:0]);
   // cursor after a scroll: one row up, floored at zero
   assign cur_post = (cur_ff >= WC_W'(cols_eff)) ? cur_ff - WC_W'(cols_eff) : '0;

   assign rsp_load = (state_ff == tcw_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      div_start    = 1'b0;
      div_dividend = pos_ff;
      div_divisor  = DIV_CELLS;
      ram_we       = 1'b0;
      ram_waddr    = scan_ff;
      ram_wdata    = {attr_ff, tcw_pkg::CH_SPACE};
      ram_re       = 1'b0;
      ram_raddr    = src16[AW-1:0];

      case (state_ff)
         tcw_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            if (clr_ff == LAST_CELL) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end

         tcw_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = tcw_pkg::ST_DECODE;
            end
         end

         tcw_pkg::ST_DECODE: begin
            if (cmd_ff == tcw_pkg::CMD_READ) begin
               op_in        = tcw_pkg::OP_READ;
               div_start    = 1'b1;
               div_dividend = idx_ff;
               state_in     = tcw_pkg::ST_DIV_WAIT;
            end else if ((cmd_ff == tcw_pkg::CMD_OUTPUT || is_echo) &&
                         ch_ff != tcw_pkg::CH_NUL) begin
               div_start = 1'b1;
               state_in  = tcw_pkg::ST_DIV_WAIT;
               case (ch_ff)
                  tcw_pkg::CH_LF: begin
                     op_in       = tcw_pkg::OP_NEWLINE;
                     div_divisor = DV_W'(cols_eff);
                  end
                  tcw_pkg::CH_CR: begin
                     op_in       = tcw_pkg::OP_RETURN;
                     div_divisor = DV_W'(cols_eff);
                  end
                  tcw_pkg::CH_TAB: begin
                     op_in       = tcw_pkg::OP_TAB;
                     div_divisor = DIV_TAB;
                  end
                  default: begin
                     op_in = tcw_pkg::OP_WRITE;
                     if (is_bs) begin
                        div_dividend = bs_cur;
                     end
                  end
               endcase
            end else begin
               // null character or unused command: no cell, cursor or line change
               op_in    = tcw_pkg::OP_NONE;
               state_in = tcw_pkg::ST_FINISH;
            end
         end

         tcw_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               if (op_ff == tcw_pkg::OP_READ) begin
                  ram_re    = 1'b1;
                  ram_raddr = div_rem[AW-1:0];
                  state_in  = tcw_pkg::ST_READ_DATA;
               end else begin
                  if (op_ff == tcw_pkg::OP_WRITE) begin
                     ram_we    = 1'b1;
                     ram_waddr = div_rem[AW-1:0];
                     ram_wdata = {attr_ff, wch_ff};
                  end
                  state_in = tcw_pkg::ST_SCROLL_CHECK;
               end
            end
         end

         tcw_pkg::ST_READ_DATA: begin
            state_in = tcw_pkg::ST_FINISH;
         end

         tcw_pkg::ST_SCROLL_CHECK: begin
            if (16'(cur_ff) >= size16) begin
               state_in = tcw_pkg::ST_SCROLL_RD;
            end else begin
               state_in = tcw_pkg::ST_FINISH;
            end
         end

         tcw_pkg::ST_SCROLL_RD: begin
            if (src16 < size16) begin
               // fetch the cell one row below
               ram_re   = 1'b1;
               state_in = tcw_pkg::ST_SCROLL_WR;
            end else begin
               // last row: blank it
               ram_we = 1'b1;
               if (scan_last) begin
                  state_in = tcw_pkg::ST_FINISH;
               end
            end
         end

         tcw_pkg::ST_SCROLL_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            if (scan_last) begin
               state_in = tcw_pkg::ST_FINISH;
            end else begin
               state_in = tcw_pkg::ST_SCROLL_RD;
            end
         end

         tcw_pkg::ST_FINISH: begin
            if (rsp_load) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tcw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcw_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= tcw_pkg::ATTR_RESET;
         cols_ff <= tcw_pkg::COLS_RESET;
         rows_ff <= tcw_pkg::ROWS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            tcw_pkg::CSR_ATTRIBUTE: attr_ff <= csr_wdata;
            tcw_pkg::CSR_COLUMNS:   cols_ff <= csr_wdata;
            tcw_pkg::CSR_ROWS:      rows_ff <= csr_wdata[tcw_pkg::ROWS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         pos_ff      <= '0;
         line_len_ff <= '0;
      end else begin
         case (state_ff)
            tcw_pkg::ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
            end

            tcw_pkg::ST_IDLE: begin
               cmd_ff <= req_chan.cmd;
               ch_ff  <= req_chan.char_code;
               idx_ff <= req_chan.cell_index;
            end

            tcw_pkg::ST_DECODE: begin
               op_ff   <= op_in;
               size_ff <= size_in;
               rd_ff   <= '0;
               done_ff <= 1'b0;
               scr_ff  <= 1'b0;
               if (op_in == tcw_pkg::OP_WRITE && is_bs) begin
                  wch_ff <= tcw_pkg::CH_SPACE;
                  cur_ff <= WC_W'(bs_cur);
                  if (line_len_ff != '0) begin
                     line_len_ff <= line_len_ff - 1'b1;
                  end
               end else begin
                  wch_ff <= ch_ff;
                  cur_ff <= WC_W'(pos_ff) + WC_W'(1);
                  if (op_in == tcw_pkg::OP_NEWLINE) begin
                     if (is_echo) begin
                        done_ff     <= 1'b1;
                        line_len_ff <= '0;
                     end
                  end else if (op_in != tcw_pkg::OP_READ && op_in != tcw_pkg::OP_NONE &&
                               is_echo && line_len_ff != tcw_pkg::LINE_MAX) begin
                     line_len_ff <= line_len_ff + 1'b1;
                  end
               end
            end

            tcw_pkg::ST_DIV_WAIT: begin
               if (div_done) begin
                  case (op_ff)
                     tcw_pkg::OP_NEWLINE: cur_ff <= cur_base + WC_W'(cols_eff);
                     tcw_pkg::OP_RETURN:  cur_ff <= cur_base;
                     tcw_pkg::OP_TAB:     cur_ff <= cur_base + WC_W'(TAB_WIDTH);
                     default: begin
                     end
                  endcase
               end
            end

            tcw_pkg::ST_READ_DATA: begin
               rd_ff <= ram_rdata;
            end

            tcw_pkg::ST_SCROLL_CHECK: begin
               scan_ff <= '0;
               if (16'(cur_ff) >= size16) begin
                  scr_ff <= 1'b1;
                  pos_ff <= cur_post[tcw_pkg::CUR_W-1:0];
               end else begin
                  pos_ff <= cur_ff[tcw_pkg::CUR_W-1:0];
               end
            end

            tcw_pkg::ST_SCROLL_RD: begin
               if (src16 >= size16) begin
                  scan_ff <= scan_ff + 1'b1;
               end
            end

            tcw_pkg::ST_SCROLL_WR: begin
               scan_ff <= scan_ff + 1'b1;
            end

            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_cursor_ff <= pos_ff;
         rsp_data_ff   <= rd_ff;
         rsp_done_ff   <= done_ff;
         rsp_scr_ff    <= scr_ff;
      end
   end

   assign req_chan.ready     = (state_ff == tcw_pkg::ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.cursor    = rsp_cursor_ff;
   assign rsp_chan.read_data = rsp_data_ff;
   assign rsp_chan.line_done = rsp_done_ff;
   assign rsp_chan.scrolled  = rsp_scr_ff;

   // ---------------------------------------------------------------- shared units
   tcw_rem_unit #(
      .DV_W (DV_W)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .rem      (div_rem)
   );

   tcw_cell_ram #(
      .DEPTH (MAX_CELLS),
      .AW    (AW)
   ) u_cells (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule
